/* src/dnnr_pkg.sv */
`timescale 1ns / 1ps

package dnnr_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_QUADS   = 32;
    localparam int LANE_BITS   = 16;

    localparam int ENTRY_W  = $clog2(MAX_ENTRIES);
    localparam int QUAD_W   = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
    localparam int QLIM_W   = $clog2(MAX_QUADS + 1);
    localparam int NLIM_W   = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W   = 4 * LANE_BITS;
    localparam int ADDR_W   = ENTRY_W + QUAD_W;
    localparam int SQ_W     = 2 * LANE_BITS;
    localparam int SUM_W    = SQ_W + 2;
    localparam int DIST_W   = 40;
    localparam int ACC_W    = ((SUM_W > DIST_W) ? SUM_W : DIST_W) + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int CFG_W = 11;
    localparam logic CFG_MODEL_COUNT = 1'b0;
    localparam logic CFG_QUAD_COUNT  = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               start;
        logic               issue;
        logic [ENTRY_W-1:0] entry;
        logic [QUAD_W-1:0]  quad;
        logic               first;
        logic               last;
        logic               use_q;
        logic               result;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_valid;
    } t_stat;

endpackage

/* src/dnnr_ram.sv */
`timescale 1ns / 1ps

module dnnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dnnr_ctrl.sv */
`timescale 1ns / 1ps

module dnnr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [dnnr_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_user,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  dnnr_pkg::t_stat      i_stat,
    output dnnr_pkg::t_cmd       o_cmd
);
    import dnnr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CFG_W-1:0]   r_model_count;
    logic [5:0]         r_quad_count;
    logic [ENTRY_W-1:0] r_entry, n_entry;
    logic [QUAD_W-1:0]  r_quad, n_quad;

    logic [NLIM_W-1:0] n_lim;
    logic [QLIM_W-1:0] q_lim;
    logic [QLIM_W-1:0] q_iter;
    logic              start;
    logic              accept;
    logic              quad_end;
    logic              entry_end;

    assign n_lim  = (r_model_count > CFG_W'(MAX_ENTRIES)) ? NLIM_W'(MAX_ENTRIES)
                                                         : NLIM_W'(r_model_count);
    assign q_lim  = (r_quad_count > 6'(MAX_QUADS)) ? QLIM_W'(MAX_QUADS)
                                                  : QLIM_W'(r_quad_count);
    // an empty descriptor still takes one pass per entry
    assign q_iter = (q_lim == '0) ? QLIM_W'(1) : q_lim;

    assign o_in_ready = (r_state == S_IDLE) &&
                        (!i_stat.out_valid || !(i_in_user == REQ_QUERY && i_in_last));
    assign accept     = i_in_valid && o_in_ready;
    assign start      = accept && (i_in_user == REQ_QUERY) && i_in_last;
    assign quad_end   = (QLIM_W'(r_quad) == q_iter - QLIM_W'(1));
    assign entry_end  = (NLIM_W'(r_entry) == n_lim - NLIM_W'(1));

    always_comb begin
        n_state = r_state;
        n_entry = r_entry;
        n_quad  = r_quad;
        case (r_state)
            S_IDLE: begin
                n_entry = '0;
                n_quad  = '0;
                if (start) begin
                    n_state = (n_lim == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (quad_end) begin
                    n_quad  = '0;
                    n_entry = r_entry + ENTRY_W'(1);
                    if (entry_end) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_quad = r_quad + QUAD_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry       <= '0;
            r_quad        <= '0;
            r_model_count <= '0;
            r_quad_count  <= 6'(MAX_QUADS);
        end else begin
            r_state <= n_state;
            r_entry <= n_entry;
            r_quad  <= n_quad;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODEL_COUNT: r_model_count <= i_cfg_data;
                    CFG_QUAD_COUNT:  r_quad_count  <= i_cfg_data[5:0];
                    default:         r_model_count <= r_model_count;
                endcase
            end
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = start;
        o_cmd.issue  = (r_state == S_SCAN);
        o_cmd.entry  = r_entry;
        o_cmd.quad   = r_quad;
        o_cmd.first  = (r_quad == '0);
        o_cmd.last   = quad_end;
        o_cmd.use_q  = (q_lim != '0);
        o_cmd.result = (r_state == S_RESULT);
    end

`ifndef SYNTH
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan did not start after last query word");
    a_quad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (QLIM_W'(r_quad) < q_iter))
        else $error("quad counter beyond descriptor length");
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |=> i_stat.out_valid)
        else $error("result not presented");
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> !i_stat.busy)
        else $error("result taken while pipeline busy");
`endif

endmodule

/* src/dnnr_dp.sv */
`timescale 1ns / 1ps

module dnnr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_req,
    input  logic [dnnr_pkg::ENTRY_W-1:0] i_entry,
    input  logic [dnnr_pkg::QUAD_W-1:0] i_quad,
    input  logic [1:0]                  i_sign,
    input  logic [dnnr_pkg::WORD_W-1:0] i_word,
    input  dnnr_pkg::t_cmd              i_cmd,
    output dnnr_pkg::t_stat             o_stat,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [dnnr_pkg::ENTRY_W-1:0] o_index,
    output logic [dnnr_pkg::DIST_W-1:0] o_dist
);
    import dnnr_pkg::*;

    logic [WORD_W-1:0] model_rd, query_rd;
    logic [1:0]        sign_rd;
    logic              load_we, query_we;

    assign load_we  = i_accept && (i_req == REQ_LOAD);
    assign query_we = i_accept && (i_req == REQ_QUERY);

    dnnr_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES * MAX_QUADS)) u_model (
        .i_clk(i_clk), .i_we(load_we), .i_waddr({i_entry, i_quad}), .i_wdata(i_word),
        .i_raddr({i_cmd.entry, i_cmd.quad}), .o_rdata(model_rd)
    );
    dnnr_ram #(.WIDTH(2), .DEPTH(MAX_ENTRIES)) u_sign (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(i_entry), .i_wdata(i_sign),
        .i_raddr(i_cmd.entry), .o_rdata(sign_rd)
    );
    dnnr_ram #(.WIDTH(WORD_W), .DEPTH(MAX_QUADS)) u_query (
        .i_clk(i_clk), .i_we(query_we), .i_waddr(i_quad), .i_wdata(i_word),
        .i_raddr(i_cmd.quad), .o_rdata(query_rd)
    );

    logic [1:0] r_qsign;

    logic               r_v1, r_f1, r_l1, r_u1;
    logic [ENTRY_W-1:0] r_e1;
    logic               r_v2, r_f2, r_l2, r_u2, r_m2;
    logic [ENTRY_W-1:0] r_e2;
    logic [SQ_W-1:0]    r_sq [4];
    logic               r_v3, r_f3, r_l3, r_m3;
    logic [ENTRY_W-1:0] r_e3;
    logic [SUM_W-1:0]   r_sum3;
    logic               r_dv;
    logic [ENTRY_W-1:0] r_e4;
    logic [DIST_W-1:0]  r_acc;

    logic [DIST_W-1:0]  r_best, r_second;
    logic [ENTRY_W-1:0] r_best_idx;
    logic               r_have;

    logic               r_out_valid, r_found;
    logic [ENTRY_W-1:0] r_index;
    logic [DIST_W-1:0]  r_dist;

    logic [SQ_W-1:0]   n_sq [4];
    logic [SUM_W-1:0]  n_sum;
    logic [ACC_W-1:0]  acc_sum;
    logic [DIST_W-1:0] n_acc;
    logic [DIST_W+2:0] best_x5;
    logic [DIST_W+2:0] second_x3;

    always_comb begin
        logic signed [LANE_BITS:0]     d;
        logic signed [2*LANE_BITS+1:0] p;
        for (int k = 0; k < 4; k++) begin
            d = $signed({query_rd[k*LANE_BITS+LANE_BITS-1], query_rd[k*LANE_BITS +: LANE_BITS]})
              - $signed({model_rd[k*LANE_BITS+LANE_BITS-1], model_rd[k*LANE_BITS +: LANE_BITS]});
            p = d * d;
            n_sq[k] = p[SQ_W-1:0];
        end
    end

    assign n_sum = r_u2 ? (SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2])
                           + SUM_W'(r_sq[3])) : '0;

    // squares are never negative, so one clamp per quad matches a running clamp
    assign acc_sum = (r_f3 ? ACC_W'(0) : ACC_W'(r_acc)) + ACC_W'(r_sum3);
    assign n_acc   = (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];

    assign best_x5   = (DIST_W+3)'({r_best, 2'b00}) + (DIST_W+3)'(r_best);
    assign second_x3 = (DIST_W+3)'({r_second, 1'b0}) + (DIST_W+3)'(r_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsign     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (query_we) begin
                r_qsign <= i_sign;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_dv <= r_v3 && r_l3 && r_m3;
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= i_cmd.first;
        r_l1 <= i_cmd.last;
        r_u1 <= i_cmd.use_q;
        r_e1 <= i_cmd.entry;

        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_u2 <= r_u1;
        r_e2 <= r_e1;
        r_m2 <= (sign_rd == r_qsign);
        for (int k = 0; k < 4; k++) begin
            r_sq[k] <= n_sq[k];
        end

        r_f3   <= r_f2;
        r_l3   <= r_l2;
        r_m3   <= r_m2;
        r_e3   <= r_e2;
        r_sum3 <= n_sum;

        if (r_v3) begin
            r_acc <= n_acc;
            r_e4  <= r_e3;
        end

        // keep the earlier index on ties
        if (i_cmd.start) begin
            r_best     <= DIST_MAX;
            r_second   <= DIST_MAX;
            r_best_idx <= '0;
            r_have     <= 1'b0;
        end else if (r_dv) begin
            if (r_acc < r_best) begin
                r_second   <= r_best;
                r_best     <= r_acc;
                r_best_idx <= r_e4;
                r_have     <= 1'b1;
            end else if (r_acc < r_second) begin
                r_second <= r_acc;
            end
        end

        if (i_cmd.result) begin
            r_found <= r_have && (best_x5 < second_x3);
            r_index <= (r_have && (best_x5 < second_x3)) ? r_best_idx : '0;
            r_dist  <= r_best;
        end
    end

    assign o_stat.busy      = r_v1 || r_v2 || r_v3 || r_dv;
    assign o_stat.out_valid = r_out_valid;
    assign o_found          = r_found;
    assign o_index          = r_index;
    assign o_dist           = r_dist;

endmodule

/* src/descriptor_nearest_neighbor_ratio.sv */
`timescale 1ns / 1ps
// Load and non-final query words only write memory and give no result.
// A final query word starts a scan of min(model_count, 1024) * max(min(quad_count, 32), 1)
// model words, one model word per cycle, then drain and result (no scan when
// model_count is zero); the result waits in an output register and holds off the next
// final query word. Reset (synchronous, active low) clears control, counts and query
// sign; the descriptor memories are not cleared and hold garbage until written.
module descriptor_nearest_neighbor_ratio (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index, quad_index, sign_class, lane0, lane1, lane2, lane3, zero pad
    input  logic [87:0] i_s_axis_tdata,
    // req_type
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // neighbor_index, best_distance, zero pad
    output logic [55:0] o_m_axis_tdata,
    // found
    output logic        o_m_axis_tuser
);
    import dnnr_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  accept;
    logic  found;
    logic [ENTRY_W-1:0] index;
    logic [DIST_W-1:0]  best_dist;
    logic [WORD_W-1:0]  word;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign word   = {i_s_axis_tdata[65 +: LANE_BITS], i_s_axis_tdata[49 +: LANE_BITS],
                     i_s_axis_tdata[33 +: LANE_BITS], i_s_axis_tdata[17 +: LANE_BITS]};

    dnnr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_s_axis_tvalid), .i_in_user(i_s_axis_tuser),
        .i_in_last(i_s_axis_tlast), .o_in_ready(o_s_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    dnnr_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_accept(accept), .i_req(i_s_axis_tuser),
        .i_entry(i_s_axis_tdata[ENTRY_W-1:0]),
        .i_quad(i_s_axis_tdata[10 +: QUAD_W]),
        .i_sign(i_s_axis_tdata[16:15]),
        .i_word(word),
        .i_cmd(cmd), .o_stat(stat),
        .i_out_ready(i_m_axis_tready),
        .o_found(found), .o_index(index), .o_dist(best_dist)
    );

    assign o_m_axis_tvalid = stat.out_valid;
    assign o_m_axis_tuser  = found;
    assign o_m_axis_tdata  = {6'b0, best_dist, index};

endmodule

/* dv/descriptor_nearest_neighbor_ratio_tb.sv */
`timescale 1ns / 1ps

module descriptor_nearest_neighbor_ratio_tb;
    import dnnr_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic             req;
        logic [9:0]       entry;
        logic [4:0]       quad;
        logic [1:0]       cls;
        logic [3:0][15:0] lanes;
        logic             last;
    } word_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  idx;
        logic [39:0] distance;
    } match_t;

    typedef struct packed {
        logic        is_cfg;
        logic        cidx;
        logic [10:0] cval;
        word_t       w;
        logic        typed;
        match_t      r;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [87:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [55:0] m_data;
    logic        m_user;

    descriptor_nearest_neighbor_ratio uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    logic [63:0] model_words [0:32767];
    logic [1:0]  model_cls [0:1023];
    logic [63:0] query_words [0:31];
    logic [1:0]  query_cls;
    int unsigned pred_count;
    int unsigned pred_quads;

    match_t pending_matches[$];
    int     mismatches = 0;
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_go = 0;
    int     idle_cycles = 0;

    function automatic logic [39:0] entry_dist(int e, int quads);
        longint total;
        longint d;
        total = 0;
        for (int q = 0; q < quads; q++) begin
            for (int k = 0; k < 4; k++) begin
                d = longint'($signed(query_words[q][16*k +: 16]))
                    - longint'($signed(model_words[e*32+q][16*k +: 16]));
                total += d * d;
                if (total > longint'(DIST_MAX)) total = longint'(DIST_MAX);
            end
        end
        return total[39:0];
    endfunction

    // update state for an accepted word; return 1 when it yields a match result
    function automatic bit predict_word(word_t w, output match_t res);
        int     n;
        int     quads;
        longint best;
        longint second;
        longint d;
        int     best_idx;
        bit     have;
        n = 0;
        quads = 0;
        best = DIST_MAX;
        second = DIST_MAX;
        best_idx = 0;
        have = 0;
        res = '0;
        if (w.req == REQ_LOAD) begin
            model_words[w.entry*32 + w.quad] = w.lanes;
            model_cls[w.entry] = w.cls;
            return 0;
        end
        query_words[w.quad] = w.lanes;
        query_cls = w.cls;
        if (!w.last) return 0;
        n = (pred_count > MAX_ENTRIES) ? MAX_ENTRIES : pred_count;
        quads = (pred_quads > MAX_QUADS) ? MAX_QUADS : pred_quads;
        for (int i = 0; i < n; i++) begin
            if (model_cls[i] == query_cls) begin
                d = entry_dist(i, quads);
                if (d < best) begin
                    second = best;
                    best = d;
                    best_idx = i;
                    have = 1;
                end else if (d < second) begin
                    second = d;
                end
            end
        end
        res.found = have && (best * 5 < second * 3);
        res.idx = res.found ? best_idx[9:0] : 10'd0;
        res.distance = best[39:0];
        return 1;
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_MODEL_COUNT) pred_count = val;
        else pred_quads = val & 11'h3F;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(word_t w, bit typed, match_t typed_res);
        match_t res;
        int     gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= w.req;
        s_last <= w.last;
        s_data <= {7'd0, w.lanes[3], w.lanes[2], w.lanes[1], w.lanes[0],
                   w.cls, w.quad, w.entry};
        do @(posedge i_clk); while (!s_ready);
        if (predict_word(w, res)) pending_matches.push_back(typed ? typed_res : res);
    endtask

    // receiver: random stall, plus a long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        match_t want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected word: %h found %b", m_data, m_user);
            end else begin
                want = pending_matches.pop_front();
                if (m_user !== want.found || m_data[9:0] !== want.idx
                        || m_data[49:10] !== want.distance) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp found %b idx %0d dist %0d, got %b %0d %0d",
                                 want.found, want.idx, want.distance,
                                 m_user, m_data[9:0], m_data[49:10]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("descriptor_nearest_neighbor_ratio_tb: FAIL");
            $finish;
        end
    end

    function automatic row_t mk_item(logic req, int entry, int quad, int cls,
                                     int l0, int l1, int l2, int l3, logic last);
        row_t r;
        r = '0;
        r.w.req = req;
        r.w.entry = 10'(entry);
        r.w.quad = 5'(quad);
        r.w.cls = 2'(cls);
        r.w.lanes = {l3[15:0], l2[15:0], l1[15:0], l0[15:0]};
        r.w.last = last;
        return r;
    endfunction

    function automatic row_t mk_cfg(logic idx, int val);
        row_t r;
        r = '0;
        r.is_cfg = 1;
        r.cidx = idx;
        r.cval = 11'(val);
        return r;
    endfunction

    function automatic row_t with_match(row_t r, logic found, int idx, logic [39:0] dval);
        r.typed = 1;
        r.r.found = found;
        r.r.idx = 10'(idx);
        r.r.distance = dval;
        return r;
    endfunction

    function automatic logic [15:0] rand_lane();
        if ($urandom_range(4) == 0) return 16'($urandom);
        return 16'($urandom_range(8) - 4);
    endfunction

    function automatic logic [1:0] rand_cls();
        if ($urandom_range(9) == 0) return 2'($urandom_range(3));
        return 2'($urandom_range(1));
    endfunction

    function automatic word_t rand_word(logic req, int entry, int quad, logic [1:0] cls,
                                        logic last);
        word_t w;
        w.req = req;
        w.entry = 10'(entry);
        w.quad = 5'(quad);
        w.cls = cls;
        for (int k = 0; k < 4; k++) w.lanes[k] = rand_lane();
        w.last = last;
        return w;
    endfunction

    task automatic load_all(int n, int quads);
        for (int e = 0; e < n; e++)
            for (int q = 0; q < quads; q++)
                send_word(rand_word(REQ_LOAD, e, q, rand_cls(), 1'($urandom_range(1))),
                          0, '0);
    endtask

    task automatic query_seq(int quads);
        logic [1:0] cls;
        cls = rand_cls();
        for (int q = 0; q < quads; q++)
            send_word(rand_word(REQ_QUERY, $urandom, q, cls, q == quads - 1), 0, '0);
    endtask

    initial begin
        row_t table_rows[$];
        int   n;
        int   quads;
        int   cnt;
        int   pick;
        bit   query_ok;

        pred_count = 0;
        pred_quads = 32;
        query_cls = 0;

        // empty model at reset: nothing scanned
        table_rows.push_back(with_match(mk_item(REQ_QUERY, 0, 0, 0, 1, 2, 3, 4, 1),
                                        0, 0, DIST_MAX));
        table_rows.push_back(mk_cfg(CFG_QUAD_COUNT, 0));
        table_rows.push_back(mk_cfg(CFG_MODEL_COUNT, 2));
        // load words ignore tlast
        table_rows.push_back(mk_item(REQ_LOAD, 0, 0, 0, 32767, -32768, 0, -1, 1));
        table_rows.push_back(mk_item(REQ_LOAD, 1, 0, 1, -32768, 32767, -1, 0, 0));
        // zero length: a single match has distance zero and passes
        table_rows.push_back(with_match(mk_item(REQ_QUERY, 1023, 0, 0, 5, 5, 5, 5, 1),
                                        1, 0, 0));
        table_rows.push_back(mk_item(REQ_LOAD, 1, 0, 0, 7, 7, 7, 7, 0));
        table_rows.push_back(with_match(mk_item(REQ_QUERY, 0, 0, 0, 5, 5, 5, 5, 1),
                                        0, 0, 0));
        table_rows.push_back(mk_cfg(CFG_QUAD_COUNT, 1));
        table_rows.push_back(mk_item(REQ_LOAD, 0, 0, -2, 32767, 32767, 32767, 32767, 0));
        table_rows.push_back(mk_item(REQ_LOAD, 1, 0, -2, -32768, -32768, -32768, -32768, 0));
        table_rows.push_back(with_match(
            mk_item(REQ_QUERY, 0, 0, -2, 32767, 32767, 32767, 32767, 1), 1, 0, 0));
        // no class match
        table_rows.push_back(with_match(mk_item(REQ_QUERY, 0, 0, -1, 0, 0, 0, 0, 1),
                                        0, 0, DIST_MAX));
        // tie: lowest index wins but ratio fails
        table_rows.push_back(mk_item(REQ_LOAD, 1, 0, -2, 32767, 32767, 32767, 32767, 0));
        table_rows.push_back(with_match(
            mk_item(REQ_QUERY, 0, 0, -2, 32767, 32767, 32767, 32767, 1), 0, 0, 0));
        table_rows.push_back(mk_item(REQ_LOAD, 1, 0, -2, 32766, 1, -3, 2, 0));
        table_rows.push_back(mk_item(REQ_QUERY, 0, 0, -2, 0, 0, 0, 0, 1));
        table_rows.push_back(mk_item(REQ_LOAD, 1023, 31, 1, -1, -1, -1, -1, 0));
        table_rows.push_back(mk_item(REQ_QUERY, 1023, 31, 1, -1, -1, -1, -1, 0));
        table_rows.push_back(mk_item(REQ_QUERY, 0, 0, -2, 32766, 0, 0, 0, 1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) write_reg(table_rows[i].cidx, table_rows[i].cval);
            else send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].r);
        end

        // long descriptors, count register above the limit
        write_reg(CFG_MODEL_COUNT, 3);
        write_reg(CFG_QUAD_COUNT, 63);
        load_all(3, 32);
        repeat (2) query_seq(32);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 52 : 0;
            recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 16 : 0;
            for (int ph = 0; ph < 2; ph++) begin
                n = $urandom_range(1, 12);
                quads = $urandom_range(1, 4);
                write_reg(CFG_MODEL_COUNT, 11'(n));
                write_reg(CFG_QUAD_COUNT, 11'(quads));
                load_all(n, quads);
                query_ok = 0;
                // hold the receiver off so the result register fills and the input stalls
                if (mode == 2 && ph == 0) hold_go = 1;
                cnt = 0;
                while (cnt < 50) begin
                    pick = $urandom_range(99);
                    if (pick < 60 || !query_ok) begin
                        query_seq(quads);
                        query_ok = 1;
                        cnt += quads;
                    end else if (pick < 85) begin
                        send_word(rand_word(REQ_LOAD, $urandom_range(n - 1),
                                            $urandom_range(quads - 1), rand_cls(), 1'b0),
                                  0, '0);
                        cnt++;
                    end else if (pick < 92) begin
                        send_word(rand_word(REQ_LOAD, $urandom, $urandom, 2'($urandom),
                                            1'($urandom)), 0, '0);
                        cnt++;
                    end else begin
                        send_word(rand_word(REQ_QUERY, $urandom, $urandom, rand_cls(),
                                            1'($urandom_range(1))), 0, '0);
                        cnt++;
                    end
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("descriptor_nearest_neighbor_ratio_tb: PASS");
        end else begin
            $display("descriptor_nearest_neighbor_ratio_tb: FAIL");
        end
        $finish;
    end

endmodule

/* descriptor_nearest_neighbor_ratio.f */
src/dnnr_pkg.sv
src/dnnr_ram.sv
src/dnnr_ctrl.sv
src/dnnr_dp.sv
src/descriptor_nearest_neighbor_ratio.sv
dv/descriptor_nearest_neighbor_ratio_tb.sv
